[rtl/fbd_pkg.sv]
// Package for the fragmented Bhattacharyya distance unit.
// Holds default parameters, fixed field widths, the iterative unit's command
// type and the sequencer's state and job codes. No dependencies.
package fbd_pkg;

    localparam int MAX_FRAGMENT_LENGTH = 256;
    localparam int MAX_FRAGMENTS       = 4096;
    localparam int COUNT_BITS          = 24;

    localparam int CFG_W          = 9;
    localparam int DIST_W         = 17;
    localparam int FRAC_W         = 16;
    localparam int STEP_W         = 6;
    localparam int COEF_STEPS     = 16;
    localparam int ROOT_Q16_STEPS = 17;
    localparam int MEAN_STEPS     = 17;

    localparam logic [CFG_W-1:0]  CFG_RESET = 9'd16;
    localparam logic [DIST_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [DIST_W-1:0] HALF_Q16  = 17'd32768;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } fbd_op_t;

    typedef struct packed {
        logic              start;
        fbd_op_t           op;
        logic [STEP_W-1:0] steps;
    } fbd_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_RUN,
        ST_STEP,
        ST_WRAP,
        ST_EMIT
    } fbd_state_t;

    typedef enum logic [3:0] {
        JOB_BIN_MUL,
        JOB_BIN_ROOT,
        JOB_DEN_MUL,
        JOB_DEN_ROOT,
        JOB_COEF_DIV,
        JOB_DIST_ROOT,
        JOB_MAP,
        JOB_MAP_ROOT,
        JOB_MAP_MUL,
        JOB_MEAN_DIV
    } fbd_job_t;

endpackage

[rtl/fbd_iter_unit.sv]
// Shared iterative unit: one compare-and-subtract per cycle, used for
// digit-by-digit square root (two radicand bits a step) and restoring division.
// Depends on fbd_pkg.
module fbd_iter_unit #(
    parameter int DEN_W = 41
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fbd_pkg::fbd_cmd_t     cmd,
    input  logic [2*DEN_W-1:0]    rad_init,
    input  logic [DEN_W+1:0]      rem_init,
    input  logic [DEN_W+1:0]      divisor,
    output logic                  busy,
    output logic [DEN_W-1:0]      result
);

    localparam int RAD_W = 2 * DEN_W;
    localparam int REM_W = DEN_W + 2;

    logic                        busy_reg, busy_next;
    logic [fbd_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    fbd_pkg::fbd_op_t            op_reg, op_next;
    logic [RAD_W-1:0]            rad_reg, rad_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [REM_W-1:0]            dvs_reg, dvs_next;
    logic [DEN_W-1:0]            root_reg, root_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb begin
        if (op_reg == fbd_pkg::OP_SQRT) begin
            rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
            trial  = {root_reg, 2'b01};
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], rad_reg[RAD_W-1]};
            trial  = dvs_reg;
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        ge   = !diff[REM_W];

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        root_next = root_reg;

        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            op_next   = cmd.op;
            rad_next  = rad_init;
            rem_next  = rem_init;
            dvs_next  = divisor;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[REM_W-1:0] : rem_sh;
            root_next = {root_reg[DEN_W-2:0], ge};
            rad_next  = (op_reg == fbd_pkg::OP_SQRT) ? (rad_reg << 2) : (rad_reg << 1);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == fbd_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        root_reg <= root_next;
    end

    assign busy   = busy_reg;
    assign result = root_reg;

endmodule

[rtl/fragmented_bhattacharyya_distance_unit.sv]
// Top level of the fragmented Bhattacharyya distance unit.
// Sequencer, accumulators, two-pass multiplier; uses fbd_pkg and fbd_iter_unit.
//
// Bin-count pairs stream in and are grouped into fragments of cfg_wr_data bins
// (0 counts as 1, values above MAX_FRAGMENT_LENGTH are clamped). Each item is
// worked one at a time and s_ready is high only between items. A bin that does
// not close a fragment takes two multiplier passes, then one root bit per
// cycle in the shared iterative unit. A closing bin adds the denominator root
// (SUM_W + 8 steps) and, where needed, the 16-step coefficient division and
// the two 17-step Q0.16 roots. The last item adds a 17-step mean division.
// Distance and status come out on m_distance/m_status; the output register
// frees the input side, but a new result waits until the previous one has
// been taken.
module fragmented_bhattacharyya_distance_unit #(
    parameter int MAX_FRAGMENT_LENGTH = fbd_pkg::MAX_FRAGMENT_LENGTH,
    parameter int MAX_FRAGMENTS       = fbd_pkg::MAX_FRAGMENTS,
    parameter int COUNT_BITS          = fbd_pkg::COUNT_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [fbd_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [COUNT_BITS-1:0]      s_count_a,
    input  logic [COUNT_BITS-1:0]      s_count_b,
    input  logic                       s_last,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [fbd_pkg::DIST_W-1:0] m_distance,
    output logic                       m_status
);

    localparam int LEN_W     = $clog2(MAX_FRAGMENT_LENGTH + 1);
    localparam int FRAG_W    = $clog2(MAX_FRAGMENTS + 1);
    localparam int SUM_W     = COUNT_BITS + LEN_W;
    localparam int BIN_ROOT_W = COUNT_BITS + 8;
    localparam int DEN_W     = SUM_W + 8;
    localparam int RAD_W     = 2 * DEN_W;
    localparam int REM_W     = DEN_W + 2;
    localparam int TOTAL_W   = FRAG_W + fbd_pkg::FRAC_W;
    localparam int MUL_W     = (SUM_W > 16) ? SUM_W : 16;
    localparam int HALF_W    = (MUL_W + 1) / 2;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DW        = fbd_pkg::DIST_W;

    fbd_pkg::fbd_state_t state_reg, state_next;
    fbd_pkg::fbd_job_t   job_reg, job_next;

    logic [fbd_pkg::CFG_W-1:0] cfg_reg, cfg_next;
    logic [DEN_W-1:0]   root_sum_reg, root_sum_next;
    logic [SUM_W-1:0]   sum_first_reg, sum_first_next;
    logic [SUM_W-1:0]   sum_second_reg, sum_second_next;
    logic [LEN_W-1:0]   bin_pos_reg, bin_pos_next;
    logic [FRAG_W-1:0]  frag_reg, frag_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               m_valid_reg, m_valid_next;

    logic [COUNT_BITS-1:0] a_reg, a_next;
    logic [COUNT_BITS-1:0] b_reg, b_next;
    logic                  last_reg, last_next;
    logic [MUL_W-1:0]      x_reg, x_next;
    logic [MUL_W-1:0]      y_reg, y_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic [DW-1:0]         dist_reg, dist_next;
    logic [DW-1:0]         res_dist_reg, res_dist_next;
    logic                  res_status_reg, res_status_next;
    logic [DW-1:0]         m_distance_reg, m_distance_next;
    logic                  m_status_reg, m_status_next;

    logic [LEN_W-1:0]         len_eff;
    logic [HALF_W-1:0]        mul_a;
    logic [HALF_W+MUL_W-1:0]  prod;

    fbd_pkg::fbd_cmd_t eng_cmd;
    logic [RAD_W-1:0]  eng_rad;
    logic [REM_W-1:0]  eng_rem;
    logic [REM_W-1:0]  eng_dvs;
    logic              eng_busy;
    logic [DEN_W-1:0]  eng_result;

    logic [DEN_W-1:0]  rs_new;
    logic [SUM_W-1:0]  sa_new;
    logic [SUM_W-1:0]  sb_new;
    logic [LEN_W-1:0]  bp_new;
    logic [DW-1:0]     q16_val;
    logic [RAD_W-1:0]  q16_rad;
    logic              do_add;
    logic [DW-1:0]     mapped;
    logic              clear_stream;

    fbd_iter_unit #(
        .DEN_W(DEN_W)
    ) u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (eng_cmd),
        .rad_init (eng_rad),
        .rem_init (eng_rem),
        .divisor  (eng_dvs),
        .busy     (eng_busy),
        .result   (eng_result)
    );

    always_comb begin
        if (cfg_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(cfg_reg) > MAX_FRAGMENT_LENGTH) begin
            len_eff = LEN_W'(MAX_FRAGMENT_LENGTH);
        end else begin
            len_eff = LEN_W'(cfg_reg);
        end
    end

    assign mul_a = (state_reg == fbd_pkg::ST_MUL_HI) ?
                   HALF_W'(x_reg[MUL_W-1:HALF_W]) : x_reg[HALF_W-1:0];
    assign prod  = mul_a * y_reg;

    assign rs_new = root_sum_reg + eng_result;
    assign sa_new = sum_first_reg + SUM_W'(a_reg);
    assign sb_new = sum_second_reg + SUM_W'(b_reg);
    assign bp_new = bin_pos_reg + 1'b1;

    assign q16_rad = RAD_W'({q16_val, {fbd_pkg::FRAC_W{1'b0}}}) << (RAD_W - 34);

    always_comb begin
        state_next      = state_reg;
        job_next        = job_reg;
        cfg_next        = cfg_wr_en ? cfg_wr_data : cfg_reg;
        root_sum_next   = root_sum_reg;
        sum_first_next  = sum_first_reg;
        sum_second_next = sum_second_reg;
        bin_pos_next    = bin_pos_reg;
        frag_next       = frag_reg;
        total_next      = total_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        a_next          = a_reg;
        b_next          = b_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        acc_next        = acc_reg;
        dist_next       = dist_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;
        m_distance_next = m_distance_reg;
        m_status_next   = m_status_reg;
        eng_cmd         = '{start: 1'b0, op: fbd_pkg::OP_SQRT, steps: '0};
        eng_rad         = '0;
        eng_rem         = '0;
        eng_dvs         = '0;
        q16_val         = dist_reg;
        do_add          = 1'b0;
        mapped          = '0;
        clear_stream    = 1'b0;

        unique case (state_reg)
            fbd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    a_next     = s_count_a;
                    b_next     = s_count_b;
                    last_next  = s_last;
                    x_next     = MUL_W'(s_count_a);
                    y_next     = MUL_W'(s_count_b);
                    job_next   = fbd_pkg::JOB_BIN_MUL;
                    state_next = fbd_pkg::ST_MUL_HI;
                end
            end
            fbd_pkg::ST_MUL_HI: begin
                acc_next   = PROD_W'(prod);
                state_next = fbd_pkg::ST_MUL_LO;
            end
            fbd_pkg::ST_MUL_LO: begin
                acc_next   = (acc_reg << HALF_W) + PROD_W'(prod);
                state_next = fbd_pkg::ST_STEP;
            end
            fbd_pkg::ST_RUN: begin
                if (!eng_busy) begin
                    state_next = fbd_pkg::ST_STEP;
                end
            end
            fbd_pkg::ST_STEP: begin
                unique case (job_reg)
                    fbd_pkg::JOB_BIN_MUL: begin
                        eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_SQRT,
                                       steps: fbd_pkg::STEP_W'(BIN_ROOT_W)};
                        eng_rad    = RAD_W'({acc_reg[2*COUNT_BITS-1:0],
                                             {fbd_pkg::FRAC_W{1'b0}}}) << (2 * LEN_W);
                        job_next   = fbd_pkg::JOB_BIN_ROOT;
                        state_next = fbd_pkg::ST_RUN;
                    end
                    fbd_pkg::JOB_BIN_ROOT: begin
                        root_sum_next   = rs_new;
                        sum_first_next  = sa_new;
                        sum_second_next = sb_new;
                        bin_pos_next    = bp_new;
                        if (bp_new >= len_eff) begin
                            x_next     = MUL_W'((sa_new == '0) ? SUM_W'(1) : sa_new);
                            y_next     = MUL_W'((sb_new == '0) ? SUM_W'(1) : sb_new);
                            job_next   = fbd_pkg::JOB_DEN_MUL;
                            state_next = fbd_pkg::ST_MUL_HI;
                        end else if (last_reg) begin
                            state_next = fbd_pkg::ST_WRAP;
                        end else begin
                            state_next = fbd_pkg::ST_IDLE;
                        end
                    end
                    fbd_pkg::JOB_DEN_MUL: begin
                        eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_SQRT,
                                       steps: fbd_pkg::STEP_W'(DEN_W)};
                        eng_rad    = {acc_reg[2*SUM_W-1:0], {fbd_pkg::FRAC_W{1'b0}}};
                        job_next   = fbd_pkg::JOB_DEN_ROOT;
                        state_next = fbd_pkg::ST_RUN;
                    end
                    fbd_pkg::JOB_DEN_ROOT: begin
                        if (root_sum_reg < eng_result) begin
                            eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_DIV,
                                           steps: fbd_pkg::STEP_W'(fbd_pkg::COEF_STEPS)};
                            eng_rem    = REM_W'(root_sum_reg);
                            eng_dvs    = REM_W'(eng_result);
                            job_next   = fbd_pkg::JOB_COEF_DIV;
                            state_next = fbd_pkg::ST_RUN;
                        end else begin
                            dist_next = '0;
                            job_next  = fbd_pkg::JOB_MAP;
                        end
                    end
                    fbd_pkg::JOB_COEF_DIV: begin
                        if (eng_result[fbd_pkg::FRAC_W-1:0] != '0) begin
                            q16_val    = fbd_pkg::ONE_Q16 -
                                         DW'(eng_result[fbd_pkg::FRAC_W-1:0]);
                            eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_SQRT,
                                           steps: fbd_pkg::STEP_W'(fbd_pkg::ROOT_Q16_STEPS)};
                            eng_rad    = q16_rad;
                            job_next   = fbd_pkg::JOB_DIST_ROOT;
                            state_next = fbd_pkg::ST_RUN;
                        end else begin
                            dist_next = '0;
                            job_next  = fbd_pkg::JOB_MAP;
                        end
                    end
                    fbd_pkg::JOB_DIST_ROOT: begin
                        dist_next = eng_result[DW-1:0];
                        job_next  = fbd_pkg::JOB_MAP;
                    end
                    fbd_pkg::JOB_MAP: begin
                        if (dist_reg >= fbd_pkg::HALF_Q16) begin
                            q16_val    = dist_reg;
                            eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_SQRT,
                                           steps: fbd_pkg::STEP_W'(fbd_pkg::ROOT_Q16_STEPS)};
                            eng_rad    = q16_rad;
                            job_next   = fbd_pkg::JOB_MAP_ROOT;
                            state_next = fbd_pkg::ST_RUN;
                        end else begin
                            x_next     = MUL_W'(dist_reg);
                            y_next     = MUL_W'(dist_reg);
                            job_next   = fbd_pkg::JOB_MAP_MUL;
                            state_next = fbd_pkg::ST_MUL_HI;
                        end
                    end
                    fbd_pkg::JOB_MAP_ROOT: begin
                        do_add = 1'b1;
                        mapped = eng_result[DW-1:0];
                    end
                    fbd_pkg::JOB_MAP_MUL: begin
                        do_add = 1'b1;
                        mapped = DW'(acc_reg >> fbd_pkg::FRAC_W);
                    end
                    fbd_pkg::JOB_MEAN_DIV: begin
                        res_dist_next = eng_result[DW-1:0];
                        state_next    = fbd_pkg::ST_EMIT;
                    end
                    default: begin
                        state_next = fbd_pkg::ST_IDLE;
                    end
                endcase

                if (do_add) begin
                    if (32'(frag_reg) < MAX_FRAGMENTS) begin
                        frag_next  = frag_reg + 1'b1;
                        total_next = total_reg + TOTAL_W'(mapped);
                    end
                    root_sum_next   = '0;
                    sum_first_next  = '0;
                    sum_second_next = '0;
                    bin_pos_next    = '0;
                    state_next      = last_reg ? fbd_pkg::ST_WRAP : fbd_pkg::ST_IDLE;
                end
            end
            fbd_pkg::ST_WRAP: begin
                if (bin_pos_reg != '0) begin
                    res_dist_next   = '0;
                    res_status_next = 1'b1;
                    state_next      = fbd_pkg::ST_EMIT;
                end else if (frag_reg == '0) begin
                    res_dist_next   = '0;
                    res_status_next = 1'b0;
                    state_next      = fbd_pkg::ST_EMIT;
                end else begin
                    res_status_next = 1'b0;
                    eng_cmd    = '{start: 1'b1, op: fbd_pkg::OP_DIV,
                                   steps: fbd_pkg::STEP_W'(fbd_pkg::MEAN_STEPS)};
                    eng_rem    = REM_W'(total_reg >> fbd_pkg::MEAN_STEPS);
                    eng_rad    = RAD_W'(total_reg[fbd_pkg::MEAN_STEPS-1:0])
                                 << (RAD_W - fbd_pkg::MEAN_STEPS);
                    eng_dvs    = REM_W'(frag_reg);
                    job_next   = fbd_pkg::JOB_MEAN_DIV;
                    state_next = fbd_pkg::ST_RUN;
                end
            end
            fbd_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_distance_next = res_dist_reg;
                    m_status_next   = res_status_reg;
                    clear_stream    = 1'b1;
                    state_next      = fbd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbd_pkg::ST_IDLE;
            end
        endcase

        if (clear_stream) begin
            root_sum_next   = '0;
            sum_first_next  = '0;
            sum_second_next = '0;
            bin_pos_next    = '0;
            frag_next       = '0;
            total_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fbd_pkg::ST_IDLE;
            job_reg        <= fbd_pkg::JOB_BIN_MUL;
            cfg_reg        <= fbd_pkg::CFG_RESET;
            root_sum_reg   <= '0;
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
            bin_pos_reg    <= '0;
            frag_reg       <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            cfg_reg        <= cfg_next;
            root_sum_reg   <= root_sum_next;
            sum_first_reg  <= sum_first_next;
            sum_second_reg <= sum_second_next;
            bin_pos_reg    <= bin_pos_next;
            frag_reg       <= frag_next;
            total_reg      <= total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        last_reg       <= last_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        acc_reg        <= acc_next;
        dist_reg       <= dist_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        m_distance_reg <= m_distance_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready    = (state_reg == fbd_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_status   = m_status_reg;

endmodule
